// ===== hw/rtl/avcc_ab_pkg.sv =====
// shared types and constants of the avcc to annex b converter
package avcc_ab_pkg;

    // status codes on the last word of an item
    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_PKT_BAD  = 3'd1;
    localparam logic [2:0] STAT_REC_BAD  = 3'd2;
    localparam logic [2:0] STAT_OVERFLOW = 3'd3;
    localparam logic [2:0] STAT_MISSING  = 3'd4;

    // nal unit type of an idr slice, taken from the low five bits
    localparam logic [4:0] NAL_TYPE_IDR = 5'd5;

    // start code bytes
    localparam logic [7:0] SC_ZERO = 8'h00;
    localparam logic [7:0] SC_ONE  = 8'h01;

    // record byte handed to the header store
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } rec_cmd_t;

    // header store status seen by the sequencer
    typedef struct packed {
        logic       busy;
        logic       header_ok;
        logic [2:0] code;
    } hdr_stat_t;

endpackage

// ===== hw/rtl/avcc_ab_in_if.sv =====
// input word channel: tagged extradata or packet bytes
interface avcc_ab_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;
    logic       is_last;

    modport source (output valid, output mode, output data_byte, output is_last, input ready);
    modport sink (input valid, input mode, input data_byte, input is_last, output ready);
endinterface

// ===== hw/rtl/avcc_ab_out_if.sv =====
// output word channel: annex b bytes with status
interface avcc_ab_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic [2:0] status;

    modport source (output valid, output out_byte, output out_last, output status, input ready);
    modport sink (input valid, input out_byte, input out_last, input status, output ready);
endinterface

// ===== hw/rtl/avcc_to_annexb_converter_core.sv =====
// avcc to annex b converter: packet nal framing and output word sequencer
// flow: an accepted packet byte leaves idle and its words go through the output word register
//   one per cycle while that register can load; header bytes alternate a read state (registered
//   store read) with an output state; the input is ready only in idle, so the next byte waits
//   until all words of this one are loaded; record bytes wait while the store writes its start
//   code sweep, and the final record byte then adds a status word
// reset: asynchronous, clears all control state; the header store is not cleared
module avcc_to_annexb_converter_core #(
    parameter int HEADER_BYTES = 48,
    parameter int LENGTH_BYTES = 4,
    localparam int IDXW = $clog2(HEADER_BYTES),
    localparam int HLW  = $clog2(HEADER_BYTES + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    avcc_ab_in_if.sink    feed,
    avcc_ab_out_if.source result
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_REC_WAIT = 3'd1;
    localparam logic [2:0] S_HDR_RD   = 3'd2;
    localparam logic [2:0] S_HDR_OUT  = 3'd3;
    localparam logic [2:0] S_SC       = 3'd4;
    localparam logic [2:0] S_BYTE     = 3'd5;
    localparam logic [2:0] S_STAT     = 3'd6;

    logic [2:0]     state_reg, state_next;
    logic [HLW-1:0] cnt_reg, cnt_next;
    logic [7:0]     byte_reg, byte_next;
    logic           last_reg, last_next;
    logic           sc4_reg, sc4_next;
    logic           bplan_reg, bplan_next;
    logic [2:0]     stat_reg, stat_next;

    logic [31:0]    acc_reg, acc_next;
    logic [2:0]     lbs_reg, lbs_next;
    logic [30:0]    left_reg, left_next;
    logic           perr_reg, perr_next;
    logic [2:0]     pcode_reg, pcode_next;
    logic           first_reg, first_next;

    logic           ov_reg, ov_next;
    logic [7:0]     ob_reg, ob_next;
    logic           ol_reg, ol_next;
    logic [2:0]     os_reg, os_next;

    logic           accept;
    logic           can_load;
    logic           ld;
    logic [7:0]     ld_byte;
    logic           ld_last;
    logic [2:0]     ld_stat;

    // packet plan for the accepted byte
    logic [31:0]    shifted;
    logic [2:0]     lbs_inc;
    logic           stop;
    logic           pl_hdr;
    logic           pl_sc;
    logic           pl_sc4;
    logic           pl_byte;
    logic [2:0]     pl_stat;
    logic           sc_end;

    avcc_ab_pkg::rec_cmd_t  cmd;
    avcc_ab_pkg::hdr_stat_t hstat;
    logic [7:0]             rd_data;
    logic [HLW-1:0]         hl;

    avcc_ab_hdr #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_hdr (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .rd_addr       (cnt_reg[IDXW-1:0]),
        .rd_data       (rd_data),
        .header_length (hl),
        .stat          (hstat)
    );

    assign feed.ready = (state_reg == S_IDLE);
    assign accept     = feed.valid && feed.ready;
    assign can_load   = !ov_reg || result.ready;

    assign cmd.valid = accept && !feed.mode;
    assign cmd.data  = feed.data_byte;
    assign cmd.last  = feed.is_last;

    // length parsing, nal framing and packet error tracking
    always_comb
    begin
        acc_next   = acc_reg;
        lbs_next   = lbs_reg;
        left_next  = left_reg;
        perr_next  = perr_reg;
        pcode_next = pcode_reg;
        first_next = first_reg;
        pl_hdr     = 1'b0;
        pl_sc      = 1'b0;
        pl_sc4     = 1'b0;
        pl_byte    = 1'b0;
        pl_stat    = avcc_ab_pkg::STAT_OK;
        stop       = 1'b0;
        shifted    = {acc_reg[23:0], feed.data_byte};
        lbs_inc    = lbs_reg + 3'd1;

        if (!perr_reg)
        begin
            if (left_reg == 31'd0)
            begin
                acc_next = shifted;
                lbs_next = lbs_inc;
                if (lbs_inc >= 3'(LENGTH_BYTES))
                begin
                    acc_next = 32'd0;
                    lbs_next = 3'd0;
                    if (shifted[31])
                    begin
                        perr_next  = 1'b1;
                        pcode_next = avcc_ab_pkg::STAT_PKT_BAD;
                    end
                    else if (shifted == 32'd0)
                    begin
                        pl_sc = 1'b1;
                    end
                    else
                    begin
                        left_next  = shifted[30:0];
                        first_next = 1'b1;
                    end
                end
            end
            else
            begin
                if (first_reg)
                begin
                    first_next = 1'b0;
                    if (feed.data_byte[4:0] == avcc_ab_pkg::NAL_TYPE_IDR)
                    begin
                        if (!hstat.header_ok)
                        begin
                            perr_next  = 1'b1;
                            pcode_next = avcc_ab_pkg::STAT_MISSING;
                            stop       = 1'b1;
                        end
                        else
                        begin
                            pl_hdr = 1'b1;
                            pl_sc  = 1'b1;
                            pl_sc4 = 1'b1;
                        end
                    end
                    else
                    begin
                        pl_sc = 1'b1;
                    end
                end
                if (!stop)
                begin
                    pl_byte   = 1'b1;
                    left_next = left_reg - 31'd1;
                end
            end
        end

        // end of packet: truncation check and rearm
        if (feed.is_last)
        begin
            if (!perr_next && (lbs_next != 3'd0 || left_next != 31'd0))
            begin
                perr_next  = 1'b1;
                pcode_next = avcc_ab_pkg::STAT_PKT_BAD;
            end
            pl_stat    = perr_next ? pcode_next : avcc_ab_pkg::STAT_OK;
            acc_next   = 32'd0;
            lbs_next   = 3'd0;
            left_next  = 31'd0;
            first_next = 1'b0;
            perr_next  = 1'b0;
            pcode_next = avcc_ab_pkg::STAT_OK;
        end
    end

    // word sequencer over header, start code, data and status words
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        sc4_next   = sc4_reg;
        bplan_next = bplan_reg;
        stat_next  = stat_reg;
        ld         = 1'b0;
        ld_byte    = avcc_ab_pkg::SC_ZERO;
        ld_last    = 1'b0;
        ld_stat    = avcc_ab_pkg::STAT_OK;
        sc_end     = (cnt_reg == (sc4_reg ? HLW'(3) : HLW'(2)));

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    last_next = feed.is_last;
                    cnt_next  = '0;
                    if (!feed.mode)
                    begin
                        state_next = S_REC_WAIT;
                    end
                    else
                    begin
                        byte_next  = feed.data_byte;
                        sc4_next   = pl_sc4;
                        bplan_next = pl_byte;
                        stat_next  = pl_stat;
                        if (pl_hdr && hl != '0)
                            state_next = S_HDR_RD;
                        else if (pl_sc)
                            state_next = S_SC;
                        else if (pl_byte)
                            state_next = S_BYTE;
                        else if (feed.is_last)
                            state_next = S_STAT;
                        else
                            state_next = S_IDLE;
                    end
                end
            end
            S_REC_WAIT:
            begin
                if (!hstat.busy)
                begin
                    if (last_reg)
                    begin
                        stat_next  = hstat.code;
                        state_next = S_STAT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_HDR_RD:
            begin
                state_next = S_HDR_OUT;
            end
            S_HDR_OUT:
            begin
                if (can_load)
                begin
                    ld      = 1'b1;
                    ld_byte = rd_data;
                    if (cnt_reg + HLW'(1) == hl)
                    begin
                        cnt_next   = '0;
                        state_next = S_SC;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + HLW'(1);
                        state_next = S_HDR_RD;
                    end
                end
            end
            S_SC:
            begin
                if (can_load)
                begin
                    ld      = 1'b1;
                    ld_byte = sc_end ? avcc_ab_pkg::SC_ONE : avcc_ab_pkg::SC_ZERO;
                    ld_last = sc_end && !bplan_reg && last_reg;
                    ld_stat = (sc_end && !bplan_reg && last_reg) ? stat_reg
                                                                 : avcc_ab_pkg::STAT_OK;
                    if (sc_end)
                    begin
                        cnt_next   = '0;
                        state_next = bplan_reg ? S_BYTE : S_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + HLW'(1);
                    end
                end
            end
            S_BYTE:
            begin
                if (can_load)
                begin
                    ld         = 1'b1;
                    ld_byte    = byte_reg;
                    ld_last    = last_reg;
                    ld_stat    = last_reg ? stat_reg : avcc_ab_pkg::STAT_OK;
                    state_next = S_IDLE;
                end
            end
            S_STAT:
            begin
                if (can_load)
                begin
                    ld         = 1'b1;
                    ld_byte    = avcc_ab_pkg::SC_ZERO;
                    ld_last    = 1'b1;
                    ld_stat    = stat_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output word register
    always_comb
    begin
        ov_next = ov_reg;
        ob_next = ob_reg;
        ol_next = ol_reg;
        os_next = os_reg;
        if (ld)
        begin
            ov_next = 1'b1;
            ob_next = ld_byte;
            ol_next = ld_last;
            os_next = ld_stat;
        end
        else if (result.ready)
        begin
            ov_next = 1'b0;
        end
    end

    // control and packet state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            last_reg  <= 1'b0;
            sc4_reg   <= 1'b0;
            bplan_reg <= 1'b0;
            stat_reg  <= avcc_ab_pkg::STAT_OK;
            acc_reg   <= 32'd0;
            lbs_reg   <= 3'd0;
            left_reg  <= 31'd0;
            perr_reg  <= 1'b0;
            pcode_reg <= avcc_ab_pkg::STAT_OK;
            first_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            sc4_reg   <= sc4_next;
            bplan_reg <= bplan_next;
            stat_reg  <= stat_next;
            ov_reg    <= ov_next;
            if (accept && feed.mode)
            begin
                acc_reg   <= acc_next;
                lbs_reg   <= lbs_next;
                left_reg  <= left_next;
                perr_reg  <= perr_next;
                pcode_reg <= pcode_next;
                first_reg <= first_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        ob_reg   <= ob_next;
        ol_reg   <= ol_next;
        os_reg   <= os_next;
    end

    assign result.valid    = ov_reg;
    assign result.out_byte = ob_reg;
    assign result.out_last = ol_reg;
    assign result.status   = os_reg;

endmodule

// ===== hw/rtl/avcc_ab_hdr.sv =====
// avcc record parser with the sps/pps header store
module avcc_ab_hdr #(
    parameter int HEADER_BYTES = 48,
    localparam int IDXW = $clog2(HEADER_BYTES),
    localparam int HLW  = $clog2(HEADER_BYTES + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  avcc_ab_pkg::rec_cmd_t cmd,
    input  logic [IDXW-1:0]       rd_addr,
    output logic [7:0]            rd_data,
    output logic [HLW-1:0]        header_length,
    output avcc_ab_pkg::hdr_stat_t stat
);

    localparam logic [3:0] PH_SKIP      = 4'd0;
    localparam logic [3:0] PH_LENSIZE   = 4'd1;
    localparam logic [3:0] PH_SPSCOUNT  = 4'd2;
    localparam logic [3:0] PH_UNIT_HI   = 4'd3;
    localparam logic [3:0] PH_UNIT_LO   = 4'd4;
    localparam logic [3:0] PH_UNIT_DATA = 4'd5;
    localparam logic [3:0] PH_PPSCOUNT  = 4'd6;
    localparam logic [3:0] PH_DONE      = 4'd7;
    localparam logic [3:0] PH_ERR       = 4'd8;

    logic [7:0] mem [HEADER_BYTES];

    logic [3:0]     phase_reg, phase_next;
    logic [7:0]     units_reg, units_next;
    logic [15:0]    ubl_reg, ubl_next;
    logic [HLW-1:0] hl_reg, hl_next;
    logic [2:0]     code_reg, code_next;
    logic [2:0]     fin_code_reg, fin_code_next;
    logic           in_sps_reg, in_sps_next;
    logic           sps_reg, sps_next;
    logic           pps_reg, pps_next;
    logic           ok_reg, ok_next;
    logic [1:0]     sweep_reg, sweep_next;
    logic           pend_last_reg, pend_last_next;

    logic           we;
    logic [7:0]     wdata;
    logic           finalize;
    logic [7:0]     units_dec;
    logic [3:0]     done_phase;
    logic [7:0]     skip_cnt;
    logic [15:0]    unit_len;
    logic [15:0]    ubl_dec;
    logic [16:0]    need;
    logic [2:0]     fc;

    // unit bookkeeping when a stored unit completes
    always_comb
    begin
        units_dec  = (units_reg != 8'd0) ? units_reg - 8'd1 : units_reg;
        done_phase = (units_dec != 8'd0) ? PH_UNIT_HI :
                     (in_sps_reg ? PH_PPSCOUNT : PH_DONE);
        skip_cnt   = units_reg + 8'd1;
        unit_len   = {ubl_reg[15:8], cmd.data};
        ubl_dec    = ubl_reg - 16'd1;
        need       = 17'(hl_reg) + 17'd4 + 17'(unit_len);
    end

    // record byte parsing and start code write sweep
    always_comb
    begin
        phase_next     = phase_reg;
        units_next     = units_reg;
        ubl_next       = ubl_reg;
        hl_next        = hl_reg;
        code_next      = code_reg;
        fin_code_next  = fin_code_reg;
        in_sps_next    = in_sps_reg;
        sps_next       = sps_reg;
        pps_next       = pps_reg;
        ok_next        = ok_reg;
        sweep_next     = sweep_reg;
        pend_last_next = pend_last_reg;
        we             = 1'b0;
        wdata          = avcc_ab_pkg::SC_ZERO;
        finalize       = 1'b0;
        fc             = avcc_ab_pkg::STAT_OK;

        if (sweep_reg != 2'd0)
        begin
            we         = 1'b1;
            wdata      = (sweep_reg == 2'd1) ? avcc_ab_pkg::SC_ONE : avcc_ab_pkg::SC_ZERO;
            hl_next    = hl_reg + HLW'(1);
            sweep_next = sweep_reg - 2'd1;
            finalize   = (sweep_reg == 2'd1) && pend_last_reg;
        end
        else if (cmd.valid)
        begin
            finalize = cmd.last;
            case (phase_reg)
                PH_SKIP:
                begin
                    if (units_reg == 8'd0)
                    begin
                        hl_next   = '0;
                        ok_next   = 1'b0;
                        sps_next  = 1'b0;
                        pps_next  = 1'b0;
                        code_next = avcc_ab_pkg::STAT_OK;
                    end
                    if (skip_cnt >= 8'd4)
                    begin
                        units_next = 8'd0;
                        phase_next = PH_LENSIZE;
                    end
                    else
                    begin
                        units_next = skip_cnt;
                    end
                end
                PH_LENSIZE:
                begin
                    phase_next = PH_SPSCOUNT;
                end
                PH_SPSCOUNT:
                begin
                    units_next  = {3'b000, cmd.data[4:0]};
                    in_sps_next = 1'b1;
                    if (cmd.data[4:0] == 5'd0)
                    begin
                        phase_next = PH_PPSCOUNT;
                    end
                    else
                    begin
                        sps_next   = 1'b1;
                        phase_next = PH_UNIT_HI;
                    end
                end
                PH_PPSCOUNT:
                begin
                    units_next  = cmd.data;
                    in_sps_next = 1'b0;
                    if (cmd.data == 8'd0)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        pps_next   = 1'b1;
                        phase_next = PH_UNIT_HI;
                    end
                end
                PH_UNIT_HI:
                begin
                    ubl_next   = {cmd.data, 8'h00};
                    phase_next = PH_UNIT_LO;
                end
                PH_UNIT_LO:
                begin
                    ubl_next = unit_len;
                    if (need > 17'(HEADER_BYTES))
                    begin
                        code_next  = avcc_ab_pkg::STAT_OVERFLOW;
                        phase_next = PH_ERR;
                    end
                    else
                    begin
                        // first start code byte now, the other three over the sweep
                        we             = 1'b1;
                        hl_next        = hl_reg + HLW'(1);
                        sweep_next     = 2'd3;
                        pend_last_next = cmd.last;
                        finalize       = 1'b0;
                        if (unit_len == 16'd0)
                        begin
                            units_next = units_dec;
                            phase_next = done_phase;
                        end
                        else
                        begin
                            phase_next = PH_UNIT_DATA;
                        end
                    end
                end
                PH_UNIT_DATA:
                begin
                    if (hl_reg < HLW'(HEADER_BYTES))
                    begin
                        we      = 1'b1;
                        wdata   = cmd.data;
                        hl_next = hl_reg + HLW'(1);
                    end
                    ubl_next = ubl_dec;
                    if (ubl_dec == 16'd0)
                    begin
                        units_next = units_dec;
                        phase_next = done_phase;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // end of record: report and rearm for the next one
        if (finalize)
        begin
            if (code_next != avcc_ab_pkg::STAT_OK)
                fc = code_next;
            else if (phase_next != PH_DONE)
                fc = avcc_ab_pkg::STAT_REC_BAD;
            else if (!sps_next || !pps_next)
                fc = avcc_ab_pkg::STAT_MISSING;
            else
                fc = avcc_ab_pkg::STAT_OK;
            fin_code_next = fc;
            ok_next       = (fc == avcc_ab_pkg::STAT_OK);
            phase_next    = PH_SKIP;
            units_next    = 8'd0;
            ubl_next      = 16'd0;
            code_next     = avcc_ab_pkg::STAT_OK;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SKIP;
            units_reg     <= 8'd0;
            ubl_reg       <= 16'd0;
            hl_reg        <= '0;
            code_reg      <= avcc_ab_pkg::STAT_OK;
            fin_code_reg  <= avcc_ab_pkg::STAT_OK;
            in_sps_reg    <= 1'b0;
            sps_reg       <= 1'b0;
            pps_reg       <= 1'b0;
            ok_reg        <= 1'b0;
            sweep_reg     <= 2'd0;
            pend_last_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            units_reg     <= units_next;
            ubl_reg       <= ubl_next;
            hl_reg        <= hl_next;
            code_reg      <= code_next;
            fin_code_reg  <= fin_code_next;
            in_sps_reg    <= in_sps_next;
            sps_reg       <= sps_next;
            pps_reg       <= pps_next;
            ok_reg        <= ok_next;
            sweep_reg     <= sweep_next;
            pend_last_reg <= pend_last_next;
        end
    end

    // header store: one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[hl_reg[IDXW-1:0]] <= wdata;
        rd_data <= mem[rd_addr];
    end

    assign header_length  = hl_reg;
    assign stat.busy      = (sweep_reg != 2'd0);
    assign stat.header_ok = ok_reg;
    assign stat.code      = fin_code_reg;

endmodule

// ===== sim/avcc_to_annexb_converter_core_test.sv =====
// testbench for the avcc to annex b converter core: byte table, random streams, word checks
`timescale 1ns / 1ps

module avcc_to_annexb_converter_core_test;

    localparam int HDR_BYTES   = 48;
    localparam int LEN_BYTES   = 4;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_LEN    = 160;

    // one input word with an optional typed-in final status
    typedef struct packed {
        logic       mode;
        logic [7:0] data;
        logic       last;
        logic       typed;
        logic [2:0] code;
    } feed_word_t;

    // one annex b output word
    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic [2:0] status;
    } word_t;

    // parse position inside a configuration record
    typedef enum logic [3:0] {
        REC_SKIP, REC_LENSIZE, REC_SPSCOUNT, REC_UNIT_HI, REC_UNIT_LO,
        REC_UNIT_DATA, REC_PPSCOUNT, REC_DONE, REC_ERR
    } rec_phase_t;

    logic clk = 1'b0;
    logic rst_n;

    avcc_ab_in_if  feed_bus ();
    avcc_ab_out_if out_bus ();

    avcc_to_annexb_converter_core #(
        .HEADER_BYTES(HDR_BYTES),
        .LENGTH_BYTES(LEN_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .feed(feed_bus),
        .result(out_bus)
    );

    // opening table, columns: mode, byte, last, typed, status
    feed_word_t opening_rows [31] = '{
        // length with bit 31 set
        {1'b1, 8'h80, 1'b0, 1'b0, avcc_ab_pkg::STAT_OK},
        {1'b1, 8'hff, 1'b0, 1'b0, avcc_ab_pkg::STAT_OK},
        {1'b1, 8'hff, 1'b0, 1'b0, avcc_ab_pkg::STAT_OK},
        {1'b1, 8'hff, 1'b1, 1'b1, avcc_ab_pkg::STAT_PKT_BAD},
        // zero-length nal, then an idr before any header
        {1'b1, 8'h00, 1'b0, 1'b0, avcc_ab_pkg::STAT_OK},
        {1'b1, 8'h00, 1'b0, 1'b0, avcc_ab_pkg::STAT_OK},
        {1'b1, 8'h00, 1'b0, 1'b0, avcc_ab_pkg::STAT_OK},
        {1'b1, 8'h00, 1'b0, 1'b0, avcc_ab_pkg::STAT_OK},
        {1'b1, 8'h00, 1'b0, 1'b0, avcc_ab_pkg::STAT_OK},
        {1'b1, 8'h00, 1'b0, 1'b0, avcc_ab_pkg::STAT_OK},
        {1'b1, 8'h00, 1'b0, 1'b0, avcc_ab_pkg::STAT_OK},
        {1'b1, 8'h01, 1'b0, 1'b0, avcc_ab_pkg::STAT_OK},
        {1'b1, 8'h65, 1'b1, 1'b1, avcc_ab_pkg::STAT_MISSING},
        // record with one sps of one byte and one empty pps
        {1'b0, 8'h01, 1'b0, 1'b0, avcc_ab_pkg::STAT_OK},
        {1'b0, 8'h64, 1'b0, 1'b0, avcc_ab_pkg::STAT_OK},
        {1'b0, 8'h00, 1'b0, 1'b0, avcc_ab_pkg::STAT_OK},
        {1'b0, 8'h1f, 1'b0, 1'b0, avcc_ab_pkg::STAT_OK},
        {1'b0, 8'hff, 1'b0, 1'b0, avcc_ab_pkg::STAT_OK},
        {1'b0, 8'he1, 1'b0, 1'b0, avcc_ab_pkg::STAT_OK},
        {1'b0, 8'h00, 1'b0, 1'b0, avcc_ab_pkg::STAT_OK},
        {1'b0, 8'h01, 1'b0, 1'b0, avcc_ab_pkg::STAT_OK},
        {1'b0, 8'h67, 1'b0, 1'b0, avcc_ab_pkg::STAT_OK},
        {1'b0, 8'h01, 1'b0, 1'b0, avcc_ab_pkg::STAT_OK},
        {1'b0, 8'h00, 1'b0, 1'b0, avcc_ab_pkg::STAT_OK},
        {1'b0, 8'h00, 1'b1, 1'b1, avcc_ab_pkg::STAT_OK},
        // idr behind the stored header, cut short inside the nal
        {1'b1, 8'h00, 1'b0, 1'b0, avcc_ab_pkg::STAT_OK},
        {1'b1, 8'h00, 1'b0, 1'b0, avcc_ab_pkg::STAT_OK},
        {1'b1, 8'h00, 1'b0, 1'b0, avcc_ab_pkg::STAT_OK},
        {1'b1, 8'h03, 1'b0, 1'b0, avcc_ab_pkg::STAT_OK},
        {1'b1, 8'h65, 1'b0, 1'b0, avcc_ab_pkg::STAT_OK},
        {1'b1, 8'h88, 1'b1, 1'b0, avcc_ab_pkg::STAT_OK}
    };

    int send_idle   = 0;
    int recv_idle   = 0;
    int hold_asks   = 0;
    int holds_done  = 0;
    int hold_cycles = 0;
    int quiet_cycles = 0;
    int errors      = 0;

    word_t annexb_due[$];
    word_t due_word;

    // converter state mirrored by the predictor
    logic [7:0] hdr_store [HDR_BYTES];
    int          hdr_len    = 0;
    rec_phase_t  rec_phase  = REC_SKIP;
    int          units_left = 0;
    int          unit_left  = 0;
    logic [2:0]  rec_code   = avcc_ab_pkg::STAT_OK;
    logic        in_sps     = 1'b0;
    logic        got_sps    = 1'b0;
    logic        got_pps    = 1'b0;
    logic        hdr_ok     = 1'b0;
    logic [31:0] len_acc    = '0;
    int          len_seen   = 0;
    logic [31:0] nal_left   = '0;
    logic        nal_first  = 1'b0;
    logic        pkt_err    = 1'b0;
    logic [2:0]  pkt_code   = avcc_ab_pkg::STAT_OK;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic word_t byte_word(logic [7:0] b);
        byte_word = '{b, 1'b0, avcc_ab_pkg::STAT_OK};
    endfunction

    function automatic word_t status_word(logic [2:0] code);
        status_word = '{8'h00, 1'b1, code};
    endfunction

    function automatic feed_word_t mk_word(logic m, logic [7:0] d);
        mk_word = '{m, d, 1'b0, 1'b0, avcc_ab_pkg::STAT_OK};
    endfunction

    task automatic mark_last(ref feed_word_t q[$]);
        feed_word_t w;
        w = q.pop_back();
        w.last = 1'b1;
        q.push_back(w);
    endtask

    task automatic finish_unit();
        if (units_left > 0)
            units_left--;
        if (units_left == 0)
            rec_phase = in_sps ? REC_PPSCOUNT : REC_DONE;
        else
            rec_phase = REC_UNIT_HI;
    endtask

    // annex b words caused by one accepted input word
    task automatic convert_byte(input feed_word_t w);
        word_t       words[$];
        word_t       tail;
        logic [31:0] len;
        logic [2:0]  code;
        logic        idr_fail;
        if (w.mode == 1'b0)
        begin
            // configuration record parse
            case (rec_phase)
                REC_SKIP:
                begin
                    if (units_left == 0)
                    begin
                        hdr_len  = 0;
                        hdr_ok   = 1'b0;
                        got_sps  = 1'b0;
                        got_pps  = 1'b0;
                        rec_code = avcc_ab_pkg::STAT_OK;
                    end
                    units_left++;
                    if (units_left >= 4)
                    begin
                        units_left = 0;
                        rec_phase  = REC_LENSIZE;
                    end
                end
                REC_LENSIZE:
                    rec_phase = REC_SPSCOUNT;
                REC_SPSCOUNT:
                begin
                    units_left = int'(w.data[4:0]);
                    in_sps     = 1'b1;
                    if (units_left == 0)
                        rec_phase = REC_PPSCOUNT;
                    else
                    begin
                        got_sps   = 1'b1;
                        rec_phase = REC_UNIT_HI;
                    end
                end
                REC_PPSCOUNT:
                begin
                    units_left = int'(w.data);
                    in_sps     = 1'b0;
                    if (units_left == 0)
                        rec_phase = REC_DONE;
                    else
                    begin
                        got_pps   = 1'b1;
                        rec_phase = REC_UNIT_HI;
                    end
                end
                REC_UNIT_HI:
                begin
                    unit_left = int'({w.data, 8'h00});
                    rec_phase = REC_UNIT_LO;
                end
                REC_UNIT_LO:
                begin
                    unit_left = unit_left | int'(w.data);
                    if (hdr_len + 4 + unit_left > HDR_BYTES)
                    begin
                        rec_code  = avcc_ab_pkg::STAT_OVERFLOW;
                        rec_phase = REC_ERR;
                    end
                    else
                    begin
                        for (int k = 0; k < 4; k++)
                        begin
                            hdr_store[hdr_len] = (k == 3) ? avcc_ab_pkg::SC_ONE
                                                          : avcc_ab_pkg::SC_ZERO;
                            hdr_len++;
                        end
                        if (unit_left == 0)
                            finish_unit();
                        else
                            rec_phase = REC_UNIT_DATA;
                    end
                end
                REC_UNIT_DATA:
                begin
                    if (hdr_len < HDR_BYTES)
                    begin
                        hdr_store[hdr_len] = w.data;
                        hdr_len++;
                    end
                    unit_left--;
                    if (unit_left == 0)
                        finish_unit();
                end
                default:
                    ;
            endcase
            // final record byte reports the record status
            if (w.last)
            begin
                if (rec_code != avcc_ab_pkg::STAT_OK)
                    code = rec_code;
                else if (rec_phase != REC_DONE)
                    code = avcc_ab_pkg::STAT_REC_BAD;
                else if (!got_sps || !got_pps)
                    code = avcc_ab_pkg::STAT_MISSING;
                else
                    code = avcc_ab_pkg::STAT_OK;
                hdr_ok     = (code == avcc_ab_pkg::STAT_OK);
                rec_phase  = REC_SKIP;
                units_left = 0;
                unit_left  = 0;
                rec_code   = avcc_ab_pkg::STAT_OK;
                words.push_back(status_word(code));
            end
        end
        else
        begin
            // length prefix or nal payload
            if (!pkt_err)
            begin
                if (nal_left == 0)
                begin
                    len_acc = {len_acc[23:0], w.data};
                    len_seen++;
                    if (len_seen >= LEN_BYTES)
                    begin
                        len      = len_acc;
                        len_acc  = '0;
                        len_seen = 0;
                        if (len[31])
                        begin
                            pkt_err  = 1'b1;
                            pkt_code = avcc_ab_pkg::STAT_PKT_BAD;
                        end
                        else if (len == 0)
                        begin
                            words.push_back(byte_word(avcc_ab_pkg::SC_ZERO));
                            words.push_back(byte_word(avcc_ab_pkg::SC_ZERO));
                            words.push_back(byte_word(avcc_ab_pkg::SC_ONE));
                        end
                        else
                        begin
                            nal_left  = len;
                            nal_first = 1'b1;
                        end
                    end
                end
                else
                begin
                    idr_fail = 1'b0;
                    if (nal_first)
                    begin
                        nal_first = 1'b0;
                        if (w.data[4:0] == avcc_ab_pkg::NAL_TYPE_IDR)
                        begin
                            if (!hdr_ok)
                            begin
                                pkt_err  = 1'b1;
                                pkt_code = avcc_ab_pkg::STAT_MISSING;
                                idr_fail = 1'b1;
                            end
                            else
                            begin
                                for (int i = 0; i < hdr_len; i++)
                                    words.push_back(byte_word(hdr_store[i]));
                                words.push_back(byte_word(avcc_ab_pkg::SC_ZERO));
                            end
                        end
                        if (!idr_fail)
                        begin
                            words.push_back(byte_word(avcc_ab_pkg::SC_ZERO));
                            words.push_back(byte_word(avcc_ab_pkg::SC_ZERO));
                            words.push_back(byte_word(avcc_ab_pkg::SC_ONE));
                        end
                    end
                    if (!idr_fail)
                    begin
                        words.push_back(byte_word(w.data));
                        nal_left--;
                    end
                end
            end
            // final packet byte carries the packet status
            if (w.last)
            begin
                if (!pkt_err && (len_seen != 0 || nal_left != 0))
                begin
                    pkt_err  = 1'b1;
                    pkt_code = avcc_ab_pkg::STAT_PKT_BAD;
                end
                if (words.size() == 0)
                    words.push_back(byte_word(8'h00));
                tail        = words.pop_back();
                tail.last   = 1'b1;
                tail.status = pkt_err ? pkt_code : avcc_ab_pkg::STAT_OK;
                words.push_back(tail);
                len_acc   = '0;
                len_seen  = 0;
                nal_left  = '0;
                nal_first = 1'b0;
                pkt_err   = 1'b0;
                pkt_code  = avcc_ab_pkg::STAT_OK;
            end
        end
        if (w.typed)
        begin
            words.delete();
            words.push_back(status_word(w.code));
        end
        foreach (words[i])
            annexb_due.push_back(words[i]);
    endtask

    // offer one word at the falling edge, hold it until taken
    task automatic send_word(input feed_word_t w);
        while (send_idle != 0 && $urandom_range(99) < send_idle)
        begin
            feed_bus.valid <= 1'b0;
            @(negedge clk);
        end
        feed_bus.valid     <= 1'b1;
        feed_bus.mode      <= w.mode;
        feed_bus.data_byte <= w.data;
        feed_bus.is_last   <= w.last;
        @(posedge clk);
        while (!feed_bus.ready)
            @(posedge clk);
        convert_byte(w);
        @(negedge clk);
    endtask

    // random configuration record, mostly well formed
    task automatic gen_record(ref feed_word_t rc[$]);
        int         kind;
        int         n;
        int         nsps;
        int         ulen;
        int         extra;
        logic       ovf;
        logic       stop;
        logic [7:0] cnt;
        kind = $urandom_range(99);
        if (kind < 10)
        begin
            extra = $urandom_range(12, 1);
            for (int i = 0; i < extra; i++)
                rc.push_back(mk_word(1'b0, 8'($urandom)));
        end
        else
        begin
            for (int i = 0; i < 5; i++)
                rc.push_back(mk_word(1'b0, 8'($urandom)));
            nsps = ($urandom_range(7) == 0) ? 0 : $urandom_range(2, 1);
            cnt = 8'($urandom);
            cnt[4:0] = 5'(nsps);
            rc.push_back(mk_word(1'b0, cnt));
            ovf  = (kind >= 88);
            stop = 1'b0;
            for (int s = 0; s < 2 && !stop; s++)
            begin
                if (s == 0)
                    n = nsps;
                else
                begin
                    n = ($urandom_range(7) == 0) ? 0 : $urandom_range(2, 1);
                    rc.push_back(mk_word(1'b0, 8'(n)));
                end
                for (int u = 0; u < n && !stop; u++)
                begin
                    ulen = ovf ? $urandom_range(16'hffff, 45) : $urandom_range(8);
                    rc.push_back(mk_word(1'b0, 8'(ulen >> 8)));
                    rc.push_back(mk_word(1'b0, 8'(ulen)));
                    if (ovf)
                        stop = 1'b1;
                    else
                        for (int i = 0; i < ulen; i++)
                            rc.push_back(mk_word(1'b0, 8'($urandom)));
                end
            end
            // trailing bytes after the record or an overflow
            if (ovf || (kind >= 60 && kind < 70))
            begin
                extra = $urandom_range(3);
                for (int i = 0; i < extra; i++)
                    rc.push_back(mk_word(1'b0, 8'($urandom)));
            end
            // record cut short
            if (kind >= 70 && kind < 88)
            begin
                extra = $urandom_range(rc.size() - 1, 1);
                repeat (extra)
                    void'(rc.pop_back());
            end
        end
        mark_last(rc);
    endtask

    // random packet of length-prefixed nals, mostly well formed
    task automatic gen_packet(ref feed_word_t pk[$]);
        int          kind;
        int          nals;
        int          len;
        int          extra;
        logic [31:0] lv;
        logic [7:0]  head;
        kind = $urandom_range(99);
        nals = $urandom_range(3, 1);
        for (int k = 0; k < nals; k++)
        begin
            len = ($urandom_range(7) == 0) ? 0 : $urandom_range(12, 1);
            lv  = len;
            if (kind >= 85 && k == nals - 1)
                lv = $urandom;
            for (int i = LEN_BYTES - 1; i >= 0; i--)
                pk.push_back(mk_word(1'b1, lv[8*i +: 8]));
            if (kind >= 85 && k == nals - 1)
            begin
                // wild length: a few bytes then the end of the packet
                extra = $urandom_range(5);
                for (int i = 0; i < extra; i++)
                    pk.push_back(mk_word(1'b1, 8'($urandom)));
            end
            else if (len > 0)
            begin
                head = 8'($urandom);
                if ($urandom_range(99) < 40)
                    head[4:0] = avcc_ab_pkg::NAL_TYPE_IDR;
                pk.push_back(mk_word(1'b1, head));
                for (int i = 1; i < len; i++)
                    pk.push_back(mk_word(1'b1, 8'($urandom)));
            end
        end
        // packet cut short
        if (kind >= 70 && kind < 85)
        begin
            extra = $urandom_range(pk.size() - 1, 1);
            repeat (extra)
                void'(pk.pop_back());
        end
        mark_last(pk);
    endtask

    // random streams under one idling setting, then drain
    task automatic run_phase(int s_pct, int r_pct, int quota);
        feed_word_t a[$];
        feed_word_t b[$];
        feed_word_t m[$];
        int         sent;
        int         pick;
        send_idle = s_pct;
        recv_idle = r_pct;
        sent = 0;
        while (sent < quota)
        begin
            a.delete();
            b.delete();
            m.delete();
            pick = $urandom_range(99);
            if (pick < 22)
                gen_record(a);
            else if (pick < 90)
                gen_packet(a);
            else
            begin
                // record and packet words interleaved
                gen_record(a);
                gen_packet(b);
                while (a.size() != 0 || b.size() != 0)
                begin
                    if (b.size() == 0 || (a.size() != 0 && $urandom_range(1) == 0))
                        m.push_back(a.pop_front());
                    else
                        m.push_back(b.pop_front());
                end
                a = m;
            end
            sent += a.size();
            foreach (a[i])
                send_word(a[i]);
        end
        feed_bus.valid <= 1'b0;
        wait (annexb_due.size() == 0);
        @(negedge clk);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch, got %0h, want %0h", $realtime, what, got, want);
        errors++;
    endtask

    // receiver ready, with a counted hold-off on request
    initial
    begin
        out_bus.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles == 0 && holds_done != hold_asks)
            begin
                holds_done++;
                hold_cycles = HOLD_LEN;
            end
            if (hold_cycles > 0)
            begin
                out_bus.ready <= 1'b0;
                hold_cycles--;
            end
            else
                out_bus.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // compare each output word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            if (annexb_due.size() == 0)
                report_mismatch("unexpected word", int'(out_bus.out_byte), 0);
            else
            begin
                due_word = annexb_due.pop_front();
                if (out_bus.out_byte !== due_word.value)
                    report_mismatch("out_byte", int'(out_bus.out_byte),
                                    int'(due_word.value));
                if (out_bus.out_last !== due_word.last)
                    report_mismatch("out_last", int'(out_bus.out_last),
                                    int'(due_word.last));
                if (out_bus.status !== due_word.status)
                    report_mismatch("status", int'(out_bus.status),
                                    int'(due_word.status));
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((feed_bus.valid && feed_bus.ready) || (out_bus.valid && out_bus.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= QUIET_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // main sequence
    initial
    begin
        rst_n              <= 1'b0;
        feed_bus.valid     <= 1'b0;
        feed_bus.mode      <= 1'b0;
        feed_bus.data_byte <= 8'h00;
        feed_bus.is_last   <= 1'b0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // opening table
        send_idle = 29;
        recv_idle = 84;
        for (int r = 0; r < $size(opening_rows); r++)
            send_word(opening_rows[r]);
        feed_bus.valid <= 1'b0;
        wait (annexb_due.size() == 0);
        @(negedge clk);

        // random streams: slow receiver, slow sender, then full rate with a long stall
        run_phase(29, 84, 70);
        run_phase(84, 29, 70);
        hold_asks++;
        run_phase(0, 0, 60);

        repeat (60)
            @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
